/* sv/cbpa_pkg.sv */
// Shared constants, types and helpers for the cache-line bump page allocator.
// No dependencies.
package cbpa_pkg;

	localparam int LINE_BYTES     = 64;
	localparam int LINES_PER_PAGE = 1024;
	localparam int LOCAL_PAGES    = 4;
	localparam int PAGE_COUNT     = 64;
	localparam int HEADER_LINES   = 2;

	localparam int ADDR_W  = 22;
	localparam int SIZE_W  = 16;
	localparam int LB_W    = $clog2(LINE_BYTES);
	localparam int LPP_W   = $clog2(LINES_PER_PAGE);
	localparam int PG_W    = $clog2(PAGE_COUNT);
	localparam int SLOT_W  = $clog2(LOCAL_PAGES);
	localparam int LINES_W = SIZE_W - LB_W + 1;
	localparam int USED_W  = LPP_W + 2;
	localparam int FRESH_W = PG_W + 1;
	localparam int CNT_W   = 32;
	localparam int FCNT_W  = PG_W + 1;
	localparam int PGSH    = LB_W + LPP_W;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_OVERSIZE = 2'd1,
		ST_NO_PAGE  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		PC_NONE  = 2'd0,
		PC_RING  = 2'd1,
		PC_REUSE = 2'd2,
		PC_FRESH = 2'd3
	} change_t;

	// datapath commands
	typedef enum logic [3:0] {
		OP_NOP,
		OP_CAPTURE,   // latch request
		OP_FREE,      // release count read-modify-write
		OP_CHECK,     // read next ring slot's counts, snapshot fifo count
		OP_RING,      // take next ring slot
		OP_POP,       // pop fifo head, read its counts
		OP_TEST,      // test popped page; rotate if busy
		OP_FRESH,     // issue fresh page
		OP_REPLACE,   // push exhausted page, install new one
		OP_BUMP,      // acquire count update and result
		OP_FAIL       // result with error status
	} op_t;

	typedef struct packed {
		op_t     op;
		change_t change;
		status_t status;
	} cbpa_cmd_t;

	typedef struct packed {
		logic is_free;
		logic oversize;
		logic need_page;
		logic next_free;
		logic fifo_left;
		logic popped_free;
		logic fresh_left;
	} cbpa_stat_t;

endpackage

/* sv/cacheline_bump_page_allocator_top.sv */
// Top level of the cache-line bump page allocator.
// Depends on cbpa_pkg, cbpa_ctrl, cbpa_datapath.
//
// A request is taken when start is high and busy low; its single result appears
// on alloc_address/status/page_change for one cycle with done high and cannot be
// stalled. A free, bump or oversize refusal runs decode then free, bump or fail;
// a ring advance adds check, decide, reread; a fresh page check, decide, fresh,
// replace; a reuse check, decide, pop, test, replace, plus pop, test, decide for
// each busy fifo entry; the single-port memories are each read then written.
module cacheline_bump_page_allocator_top import cbpa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              req_type,
	input  logic [SIZE_W-1:0] size_bytes,
	input  logic [ADDR_W-1:0] free_address,
	output logic              done,
	output logic [ADDR_W-1:0] alloc_address,
	output logic [1:0]        status,
	output logic [1:0]        page_change
);
	cbpa_cmd_t  cmd;
	cbpa_stat_t stat;

	cbpa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .stat(stat), .cmd(cmd), .busy(busy));

	cbpa_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .req_type(req_type),
		.size_bytes(size_bytes), .free_address(free_address), .stat(stat),
		.alloc_address(alloc_address), .status(status), .page_change(page_change),
		.done(done));
endmodule

/* sv/cbpa_ram.sv */
// Generic single-port RAM with registered read.
// No dependencies.
module cbpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

/* sv/cbpa_datapath.sv */
// Datapath: page ring, bump counter, counts memories with valid bits, pending fifo.
// Depends on cbpa_pkg and cbpa_ram.
module cbpa_datapath import cbpa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cbpa_cmd_t         cmd,
	input  logic              req_type,
	input  logic [SIZE_W-1:0] size_bytes,
	input  logic [ADDR_W-1:0] free_address,
	output cbpa_stat_t        stat,
	output logic [ADDR_W-1:0] alloc_address,
	output logic [1:0]        status,
	output logic [1:0]        page_change,
	output logic              done
);
	logic [PG_W-1:0]    pages_q [LOCAL_PAGES];
	logic [SLOT_W-1:0]  slot_q;
	logic [USED_W-1:0]  used_q;
	logic [FRESH_W-1:0] fresh_q;
	logic [PG_W-1:0]    head_q;
	logic [FCNT_W-1:0]  fcnt_q, scan_q;
	logic [PAGE_COUNT-1:0] valid_q;

	logic               type_q;
	logic [LINES_W-1:0] lines_q;
	logic [ADDR_W-1:0]  faddr_q;
	logic [PG_W-1:0]    got_q;

	// counts memory address and write
	logic [PG_W-1:0]  c_addr;
	logic             c_we;
	logic [CNT_W-1:0] acq_w, rel_w, acq_r, rel_r, acq_v, rel_v;
	logic [PG_W-1:0]  f_addr, f_wdata, f_rdata;
	logic             f_we;
	logic             rd_valid_q;

	logic [SLOT_W-1:0] next_slot;
	logic [PG_W-1:0]   cur_pg;
	logic [ADDR_W-PGSH-1:0] faddr_pg;
	logic              faddr_ok;

	assign next_slot = slot_q + SLOT_W'(1);
	assign cur_pg    = pages_q[slot_q];
	assign faddr_pg  = faddr_q[ADDR_W-1:PGSH];
	assign faddr_ok  = ({{PG_W{1'b0}}, faddr_pg} < (PG_W + ADDR_W - PGSH)'(PAGE_COUNT));

	assign acq_v = rd_valid_q ? acq_r : '0;
	assign rel_v = rd_valid_q ? rel_r : '0;

	always_comb begin
		// idle cycles keep reading the page the current request works on
		c_addr  = type_q ? PG_W'(faddr_q >> PGSH) : cur_pg;
		c_we    = 1'b0;
		acq_w   = acq_v;
		rel_w   = rel_v;
		f_addr  = head_q;
		f_we    = 1'b0;
		f_wdata = got_q;
		unique case (cmd.op)
			OP_CAPTURE: c_addr = PG_W'(free_address >> PGSH);
			OP_FREE: begin
				c_addr = PG_W'(faddr_q >> PGSH);
				c_we   = faddr_ok;
				rel_w  = rel_v + CNT_W'(1);
			end
			OP_CHECK:  c_addr = pages_q[next_slot];
			OP_POP:    c_addr = f_rdata;
			OP_TEST: begin
				c_addr  = got_q;
				f_addr  = PG_W'(head_q + PG_W'(fcnt_q));
				f_we    = !(acq_v == rel_v) && (fcnt_q < FCNT_W'(PAGE_COUNT));
				f_wdata = got_q;
			end
			OP_FRESH: begin
				c_addr = PG_W'(fresh_q);
				c_we   = 1'b1;
				acq_w  = '0;
				rel_w  = '0;
			end
			OP_REPLACE: begin
				f_addr  = PG_W'(head_q + PG_W'(fcnt_q));
				f_we    = (fcnt_q < FCNT_W'(PAGE_COUNT));
				f_wdata = cur_pg;
				c_addr  = got_q;
			end
			OP_BUMP: begin
				c_we  = 1'b1;
				acq_w = acq_v + CNT_W'(1);
			end
			default: ;
		endcase
	end

	cbpa_ram #(.WIDTH(CNT_W), .DEPTH(PAGE_COUNT)) u_acq (
		.clk(clk), .we(c_we), .addr(c_addr), .wdata(acq_w), .rdata(acq_r));
	cbpa_ram #(.WIDTH(CNT_W), .DEPTH(PAGE_COUNT)) u_rel (
		.clk(clk), .we(c_we), .addr(c_addr), .wdata(rel_w), .rdata(rel_r));
	cbpa_ram #(.WIDTH(PG_W), .DEPTH(PAGE_COUNT)) u_fifo (
		.clk(clk), .we(f_we), .addr(f_addr), .wdata(f_wdata), .rdata(f_rdata));

	// a write in the same cycle is never followed by a read of that entry without
	// a fresh read cycle, but forward the valid bit anyway
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			rd_valid_q <= valid_q[c_addr] || c_we;
			if (c_we)
				valid_q[c_addr] <= 1'b1;
		end
	end

	logic [USED_W-1:0] used_sum;
	assign used_sum = used_q + USED_W'(lines_q);

	always_comb begin
		stat.is_free     = type_q;
		stat.oversize    = (USED_W'(lines_q) + USED_W'(HEADER_LINES)) > USED_W'(LINES_PER_PAGE)
			|| lines_q > LINES_W'(LINES_PER_PAGE);
		stat.need_page   = used_sum > USED_W'(LINES_PER_PAGE);
		stat.next_free   = (acq_v == rel_v);
		stat.fifo_left   = scan_q != '0;
		stat.popped_free = (acq_v == rel_v);
		stat.fresh_left  = fresh_q < FRESH_W'(PAGE_COUNT);
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_CAPTURE) begin
			type_q  <= req_type;
			lines_q <= LINES_W'((size_bytes >> LB_W)) + LINES_W'(size_bytes[LB_W-1:0] != '0);
			faddr_q <= free_address;
		end
		if (cmd.op == OP_POP)
			got_q <= f_rdata;
		if (cmd.op == OP_FRESH)
			got_q <= PG_W'(fresh_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LOCAL_PAGES; i++)
				pages_q[i] <= PG_W'(i % PAGE_COUNT);
			slot_q        <= '0;
			used_q        <= USED_W'(HEADER_LINES);
			fresh_q       <= FRESH_W'(LOCAL_PAGES);
			head_q        <= '0;
			fcnt_q        <= '0;
			scan_q        <= '0;
			done          <= 1'b0;
			alloc_address <= '0;
			status        <= '0;
			page_change   <= '0;
		end else begin
			done <= 1'b0;
			unique case (cmd.op)
				OP_FREE: begin
					done          <= 1'b1;
					alloc_address <= '0;
					status        <= ST_OK;
					page_change   <= PC_NONE;
				end
				OP_CHECK: scan_q <= fcnt_q;
				OP_RING: begin
					slot_q <= next_slot;
					used_q <= USED_W'(HEADER_LINES);
				end
				OP_POP: begin
					head_q <= head_q + PG_W'(1);
					fcnt_q <= fcnt_q - FCNT_W'(1);
					scan_q <= scan_q - FCNT_W'(1);
				end
				OP_TEST:
					if (!(acq_v == rel_v) && (fcnt_q < FCNT_W'(PAGE_COUNT)))
						fcnt_q <= fcnt_q + FCNT_W'(1);
				OP_FRESH: fresh_q <= fresh_q + FRESH_W'(1);
				OP_REPLACE: begin
					if (fcnt_q < FCNT_W'(PAGE_COUNT))
						fcnt_q <= fcnt_q + FCNT_W'(1);
					pages_q[slot_q] <= got_q;
					used_q <= USED_W'(HEADER_LINES);
				end
				OP_BUMP: begin
					done          <= 1'b1;
					// a full page bumps into the next page id, wrapping at the top
					alloc_address <= ADDR_W'({cur_pg, {PGSH{1'b0}}})
						+ (ADDR_W'(used_q) << LB_W);
					status        <= ST_OK;
					page_change   <= cmd.change;
					used_q        <= used_sum;
				end
				OP_FAIL: begin
					done          <= 1'b1;
					alloc_address <= '0;
					status        <= cmd.status;
					page_change   <= PC_NONE;
				end
				default: ;
			endcase
		end
	end
endmodule

/* sv/cbpa_ctrl.sv */
// Controller state machine sequencing allocate, free and page replacement.
// Depends on cbpa_pkg.
module cbpa_ctrl import cbpa_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  cbpa_stat_t stat,
	output cbpa_cmd_t  cmd,
	output logic       busy
);
	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_FREE, S_CHECK, S_DECIDE, S_POP, S_TEST,
		S_FRESH, S_REPLACE, S_REREAD, S_BUMP, S_FAIL
	} state_t;

	state_t  state_q;
	change_t chg_q;
	status_t err_q;

	always_comb begin
		cmd.op     = OP_NOP;
		cmd.change = chg_q;
		cmd.status = err_q;
		unique case (state_q)
			S_IDLE:    cmd.op = start ? OP_CAPTURE : OP_NOP;
			S_DECODE:  cmd.op = OP_NOP;
			S_FREE:    cmd.op = OP_FREE;
			S_CHECK:   cmd.op = OP_CHECK;
			S_DECIDE:  cmd.op = stat.next_free ? OP_RING : OP_NOP;
			S_POP:     cmd.op = OP_POP;
			S_TEST:    cmd.op = OP_TEST;
			S_FRESH:   cmd.op = OP_FRESH;
			S_REPLACE: cmd.op = OP_REPLACE;
			S_REREAD:  cmd.op = OP_NOP;
			S_BUMP:    cmd.op = OP_BUMP;
			S_FAIL:    cmd.op = OP_FAIL;
			default:   cmd.op = OP_NOP;
		endcase
	end

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			chg_q   <= PC_NONE;
			err_q   <= ST_OK;
		end else begin
			unique case (state_q)
				S_IDLE:
					if (start)
						state_q <= S_DECODE;
				S_DECODE: begin
					// counts of the freed page or the current page are being read
					chg_q <= PC_NONE;
					if (stat.is_free)
						state_q <= S_FREE;
					else if (stat.oversize) begin
						err_q   <= ST_OVERSIZE;
						state_q <= S_FAIL;
					end else if (stat.need_page)
						state_q <= S_CHECK;
					else
						state_q <= S_BUMP;
				end
				S_FREE:  state_q <= S_IDLE;
				S_CHECK: state_q <= S_DECIDE;
				S_DECIDE:
					if (stat.next_free) begin
						chg_q   <= PC_RING;
						state_q <= S_REREAD;
					end else if (stat.fifo_left)
						state_q <= S_POP;
					else if (stat.fresh_left)
						state_q <= S_FRESH;
					else begin
						err_q   <= ST_NO_PAGE;
						state_q <= S_FAIL;
					end
				S_POP:  state_q <= S_TEST;
				S_TEST:
					if (stat.popped_free) begin
						chg_q   <= PC_REUSE;
						state_q <= S_REPLACE;
					end else
						// fifo port was busy with the rotate; re-read the head there
						state_q <= S_DECIDE;
				S_FRESH: begin
					chg_q   <= PC_FRESH;
					state_q <= S_REPLACE;
				end
				S_REPLACE: state_q <= S_BUMP;
				S_REREAD:  state_q <= S_BUMP;
				S_BUMP:    state_q <= S_IDLE;
				S_FAIL:    state_q <= S_IDLE;
				default:   state_q <= S_IDLE;
			endcase
		end
	end
endmodule
